[rtl/esc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package esc_pkg;

    // Calendar base and field widths
    localparam int unsigned BASE_YEAR = 1970;
    localparam int unsigned YEAR_W    = 12;
    localparam int unsigned SECS_W    = 33;   // clamped seconds, covers 2^32-1 plus the largest offset
    localparam int unsigned DAYS_W    = 17;

    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;

    // Divide by the odd part of each constant with a rounded-up reciprocal:
    // 86400 = 675 << 7, 3600 = 225 << 4, 60 = 15 << 2. For every x of the stated
    // width, (x * RECIP) >> shift is exactly floor(x / odd part).
    localparam logic [26:0] DAY_RECIP  = 27'd101806633;  // 2^36 / 675, x < 2^26
    localparam logic [13:0] HOUR_RECIP = 14'd9321;       // 2^21 / 225, x < 2^13
    localparam logic [10:0] MIN_RECIP  = 11'd1093;       // 2^14 / 15,  x < 2^10

    // Leap-rule phase of the base year
    localparam logic [1:0] BASE_MOD4   = 2'(BASE_YEAR % 4);
    localparam logic [6:0] BASE_MOD100 = 7'(BASE_YEAR % 100);
    localparam logic [8:0] BASE_MOD400 = 9'(BASE_YEAR % 400);

    localparam logic [3:0] LAST_MONTH = 4'd11;   // December, zero based

    localparam logic signed [4:0] ZONE_RESET = 5'sd8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_DAY,
        S_DIV_HOUR,
        S_DIV_MIN,
        S_YEAR,
        S_MONTH
    } state_t;

    typedef enum logic [1:0] {
        SEL_DAY,
        SEL_HOUR,
        SEL_MIN
    } div_sel_t;

    typedef struct packed {
        logic               load;
        logic               quo_step;
        logic               rem_step;
        div_sel_t           div_sel;
        logic               year_step;
        logic               month_step;
    } cmd_t;

    typedef struct packed {
        logic year_done;
        logic month_done;
    } status_t;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd1:                      len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

[rtl/epoch_seconds_to_calendar_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 UTC into a local
// Gregorian date and time. Pulse start while busy is low to launch a transaction;
// epoch_seconds is sampled on that edge only. The programmed zone offset (signed
// whole hours, reset value +8) is added before conversion, so the date rolls over
// at local midnight; a sum below zero clamps to the epoch and raises before_epoch.
// The result fields are valid from the one cycle in which done is high until the
// next start is accepted; the receiver cannot stall, so capture them then. A
// transaction runs three constant divisions (days, hours, minutes), each a
// reciprocal multiply for the quotient followed by a multiply-back and subtract
// for the remainder, then removes whole years, then whole months, one per cycle.
// A new start may be given in the done cycle. Write zone_offset_hours through
// cfg_wr_en/cfg_wr_data only while idle.
module epoch_seconds_to_calendar_core
    import esc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_wr_en,
    input  logic [4:0]         cfg_wr_data,
    // command side
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        epoch_seconds,
    // result side
    output logic               done,
    output logic [YEAR_W-1:0]  year,
    output logic [3:0]         month,
    output logic [4:0]         day_of_month,
    output logic [4:0]         hour,
    output logic [5:0]         minute,
    output logic [5:0]         second,
    output logic               before_epoch
);

    cmd_t    cmd;
    status_t status;

    // Sequence the division passes, then the year and month walks
    esc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Hold the offset register, the dividers and the calendar counters
    esc_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .epoch_seconds (epoch_seconds),
        .cmd           (cmd),
        .status        (status),
        .year          (year),
        .month         (month),
        .day_of_month  (day_of_month),
        .hour          (hour),
        .minute        (minute),
        .second        (second),
        .before_epoch  (before_epoch)
    );

endmodule

`default_nettype wire

[rtl/esc_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module esc_datapath
    import esc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [4:0]          cfg_wr_data,
    input  logic [31:0]         epoch_seconds,
    input  cmd_t                cmd,
    output status_t             status,
    output logic [YEAR_W-1:0]   year,
    output logic [3:0]          month,
    output logic [4:0]          day_of_month,
    output logic [4:0]          hour,
    output logic [5:0]          minute,
    output logic [5:0]          second,
    output logic                before_epoch
);

    localparam logic signed [16:0] HOUR_SECS_S = 17'(SECS_PER_HOUR);
    localparam logic [16:0]        DAY_SECS_C  = 17'(SECS_PER_DAY);
    localparam logic [11:0]        HOUR_SECS_C = 12'(SECS_PER_HOUR);
    localparam logic [5:0]         MIN_SECS_C  = 6'(SECS_PER_MIN);

    logic signed [4:0]   zone_offset_reg;
    logic [SECS_W-1:0]   rem_reg;
    logic [DAYS_W-1:0]   days_reg;
    logic [4:0]          hour_reg;
    logic [5:0]          minute_reg;
    logic [5:0]          second_reg;
    logic                flag_reg;
    logic [YEAR_W-1:0]   year_reg;
    logic [1:0]          mod4_reg;
    logic [6:0]          mod100_reg;
    logic [8:0]          mod400_reg;
    logic [3:0]          month_reg;

    logic signed [16:0]  offset_secs;
    logic [SECS_W:0]     total;
    logic [SECS_W-1:0]   clamped;
    logic [52:0]         day_prod;
    logic [25:0]         hour_prod;
    logic [19:0]         min_prod;
    logic [DAYS_W-1:0]   day_q;
    logic [4:0]          hour_q;
    logic [5:0]          minute_q;
    logic [SECS_W-1:0]   day_back;
    logic [16:0]         hour_back;
    logic [11:0]         min_back;
    logic [SECS_W-1:0]   back;
    logic [SECS_W-1:0]   rem_sub;
    logic                leap;
    logic [8:0]          ylen;
    logic [4:0]          mlen;

    // Apply zone offset at full width, clamp negative sums to the epoch
    always_comb
    begin
        offset_secs = 17'($signed({{12{zone_offset_reg[4]}}, zone_offset_reg}) * HOUR_SECS_S);
        total       = {2'b00, epoch_seconds} + {{17{offset_secs[16]}}, offset_secs};
        clamped     = total[SECS_W] ? '0 : total[SECS_W-1:0];
    end

    // Quotients by reciprocal multiply after dropping the power-of-two factor;
    // the remainder pass multiplies the registered quotient back and subtracts.
    always_comb
    begin
        day_prod  = {27'd0, rem_reg[32:7]} * {26'd0, DAY_RECIP};
        hour_prod = {13'd0, rem_reg[16:4]} * {12'd0, HOUR_RECIP};
        min_prod  = {10'd0, rem_reg[11:2]} * {9'd0, MIN_RECIP};
        day_q     = day_prod[52:36];
        hour_q    = hour_prod[25:21];
        minute_q  = min_prod[19:14];

        day_back  = {16'd0, days_reg} * {16'd0, DAY_SECS_C};
        hour_back = {12'd0, hour_reg} * {5'd0, HOUR_SECS_C};
        min_back  = {6'd0, minute_reg} * {6'd0, MIN_SECS_C};
        unique case (cmd.div_sel)
            SEL_DAY:  back = day_back;
            SEL_HOUR: back = {16'd0, hour_back};
            SEL_MIN:  back = {21'd0, min_back};
            default:  back = '0;
        endcase
        rem_sub = rem_reg - back;
    end

    always_comb
    begin
        leap = ((mod4_reg == 2'd0) && (mod100_reg != 7'd0)) || (mod400_reg == 9'd0);
        ylen = leap ? 9'd366 : 9'd365;
        mlen = month_len(month_reg, leap);
        status.year_done  = days_reg < {{(DAYS_W - 9){1'b0}}, ylen};
        status.month_done = (month_reg == LAST_MONTH) ||
                            (days_reg < {{(DAYS_W - 5){1'b0}}, mlen});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_offset_reg <= ZONE_RESET;
        end
        else if (cfg_wr_en)
        begin
            zone_offset_reg <= $signed(cfg_wr_data);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg    <= clamped;
            flag_reg   <= total[SECS_W];
            year_reg   <= YEAR_W'(BASE_YEAR);
            mod4_reg   <= BASE_MOD4;
            mod100_reg <= BASE_MOD100;
            mod400_reg <= BASE_MOD400;
            month_reg  <= '0;
        end
        if (cmd.quo_step)
        begin
            if (cmd.div_sel == SEL_DAY)
                days_reg <= day_q;
            if (cmd.div_sel == SEL_HOUR)
                hour_reg <= hour_q;
            if (cmd.div_sel == SEL_MIN)
                minute_reg <= minute_q;
        end
        if (cmd.rem_step)
        begin
            rem_reg <= rem_sub;
            if (cmd.div_sel == SEL_MIN)
                second_reg <= rem_sub[5:0];
        end
        // Drop one whole year, advance the leap-rule counters with it
        if (cmd.year_step && !status.year_done)
        begin
            days_reg   <= days_reg - {{(DAYS_W - 9){1'b0}}, ylen};
            year_reg   <= year_reg + YEAR_W'(1);
            mod4_reg   <= mod4_reg + 2'd1;
            mod100_reg <= (mod100_reg == 7'd99)  ? 7'd0 : mod100_reg + 7'd1;
            mod400_reg <= (mod400_reg == 9'd399) ? 9'd0 : mod400_reg + 9'd1;
        end
        if (cmd.month_step && !status.month_done)
        begin
            days_reg  <= days_reg - {{(DAYS_W - 5){1'b0}}, mlen};
            month_reg <= month_reg + 4'd1;
        end
    end

    assign year         = year_reg;
    assign month        = month_reg + 4'd1;
    assign day_of_month = days_reg[4:0] + 5'd1;
    assign hour         = hour_reg;
    assign minute       = minute_reg;
    assign second       = second_reg;
    assign before_epoch = flag_reg;

endmodule

`default_nettype wire

[rtl/esc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module esc_ctrl
    import esc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy,
    output logic    done
);

    state_t             state_reg;
    state_t             state_next;
    logic               phase_reg;
    logic               phase_next;
    logic               done_reg;
    logic               done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    // Each split computes the quotient first, then the remainder
    always_comb
    begin
        state_next    = state_reg;
        phase_next    = 1'b0;
        done_next     = 1'b0;
        cmd           = '0;
        cmd.div_sel   = SEL_DAY;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV_DAY;
                end
            end
            S_DIV_DAY:
            begin
                cmd.div_sel = SEL_DAY;
                phase_next  = ~phase_reg;
                if (!phase_reg)
                    cmd.quo_step = 1'b1;
                else
                begin
                    cmd.rem_step = 1'b1;
                    state_next   = S_DIV_HOUR;
                end
            end
            S_DIV_HOUR:
            begin
                cmd.div_sel = SEL_HOUR;
                phase_next  = ~phase_reg;
                if (!phase_reg)
                    cmd.quo_step = 1'b1;
                else
                begin
                    cmd.rem_step = 1'b1;
                    state_next   = S_DIV_MIN;
                end
            end
            S_DIV_MIN:
            begin
                cmd.div_sel = SEL_MIN;
                phase_next  = ~phase_reg;
                if (!phase_reg)
                    cmd.quo_step = 1'b1;
                else
                begin
                    cmd.rem_step = 1'b1;
                    state_next   = S_YEAR;
                end
            end
            S_YEAR:
            begin
                cmd.year_step = 1'b1;
                if (status.year_done)
                    state_next = S_MONTH;
            end
            S_MONTH:
            begin
                cmd.month_step = 1'b1;
                if (status.month_done)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    a_done_after_month: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_MONTH))
        else $error("result strobe without a finished month pass");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while still converting");

    a_start_enters_div: assert property (@(posedge clk) disable iff (!rst_n)
        (start && (state_reg == S_IDLE)) |=> (state_reg == S_DIV_DAY))
        else $error("accepted transaction did not start the day split");

    a_day_to_hour: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DIV_DAY) && phase_reg) |=>
            ((state_reg == S_DIV_HOUR) && !phase_reg))
        else $error("day split did not hand over to the hour split");

    a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !phase_reg)
        else $error("split phase left set while idle");

endmodule

`default_nettype wire
